// File: rtl/core/pav_pkg.sv
// Package for the p-adic valuation block: widths, derived constants and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package pav_pkg;

	// Operand widths.
	localparam int VALUE_WIDTH = 32;
	localparam int BASE_WIDTH  = 16;

	// Result width and saturation limits.
	localparam int VAL_W   = 6;
	localparam int VAL_MAX = 31;
	localparam int VAL_MIN = -31;

	// Exponent counter width holds any exponent of a VALUE_WIDTH operand.
	localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
	// Bit counter for the serial divider.
	localparam int BIT_W  = $clog2(VALUE_WIDTH);
	// Signed width for the difference, wide enough for the limits too.
	localparam int DIFF_W = (CNT_W + 1 > VAL_W + 1) ? CNT_W + 1 : VAL_W + 1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new transaction, numerator into the divider
		logic load_den;  // move the denominator into the divider
		logic div_init;  // clear remainder and bit counter
		logic div_step;  // one restoring division step
		logic accept;    // quotient becomes the next dividend, count it
		logic op_den;    // count goes to the denominator exponent
		logic finish;    // register the result and strobe it
	} pav_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic base_small; // base is 0 or 1
		logic v_zero;     // current dividend is zero
		logic div_last;   // last step of the current division
		logic rem_nz;     // remainder of the last division is nonzero
	} pav_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/pav_ctrl.sv
// Controller for the p-adic valuation block: sequences repeated divisions
// of each operand by the base. Depends on pav_pkg.
`default_nettype none

module pav_ctrl import pav_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire pav_stat_t stat,
	output pav_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_EVAL,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   op_den_q;

	// State register and operand select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_den_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_CHECK;
						op_den_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (stat.base_small) begin
						state_q <= S_FINISH;
					end else if (stat.v_zero) begin
						if (op_den_q) begin
							state_q <= S_FINISH;
						end else begin
							op_den_q <= 1'b1;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (stat.rem_nz) begin
						if (op_den_q) begin
							state_q <= S_FINISH;
						end else begin
							op_den_q <= 1'b1;
							state_q  <= S_CHECK;
						end
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// Command decode from the current state and status.
	always_comb begin
		cmd        = '0;
		cmd.op_den = op_den_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_CHECK: begin
				if (!stat.base_small) begin
					if (stat.v_zero) begin
						cmd.load_den = !op_den_q;
					end else begin
						cmd.div_init = 1'b1;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_EVAL: begin
				if (stat.rem_nz) begin
					cmd.load_den = !op_den_q;
				end else begin
					cmd.accept = 1'b1;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/pav_dp.sv
// Datapath for the p-adic valuation block: serial restoring divider,
// exponent counters and saturating result register. Depends on pav_pkg.
`default_nettype none

module pav_dp import pav_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [BASE_WIDTH-1:0]       prime_base,
	input  wire logic [VALUE_WIDTH-1:0]      numerator_value,
	input  wire logic [VALUE_WIDTH-1:0]      denominator_value,
	input  wire pav_cmd_t                    cmd,
	output pav_stat_t                        stat,
	output logic signed [VAL_W-1:0]          valuation,
	output logic                             base_error,
	output logic                             done
);

	logic [BASE_WIDTH-1:0]  base_q;
	logic [VALUE_WIDTH-1:0] den_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [BASE_WIDTH-1:0]  rem_q;
	logic [BIT_W-1:0]       bit_q;
	logic [CNT_W-1:0]       en_q;
	logic [CNT_W-1:0]       ed_q;
	logic                   done_q;

	logic [BASE_WIDTH:0]    trial;
	logic [BASE_WIDTH:0]    trial_sub;
	logic                   ge;
	logic signed [DIFF_W-1:0] diff;
	logic signed [VAL_W-1:0]  val_sat;

	// One restoring step: shift the next dividend bit into the remainder.
	assign trial     = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign ge        = (trial >= {1'b0, base_q});
	assign trial_sub = trial - {1'b0, base_q};

	// Status to the controller.
	assign stat.base_small = (base_q[BASE_WIDTH-1:1] == '0);
	assign stat.v_zero     = (quo_q == '0);
	assign stat.div_last   = (bit_q == BIT_W'(VALUE_WIDTH - 1));
	assign stat.rem_nz     = (rem_q != '0);

	// Operand, divider and counter registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= prime_base;
			den_q  <= denominator_value;
			quo_q  <= numerator_value;
			en_q   <= '0;
			ed_q   <= '0;
		end else begin
			if (cmd.load_den) begin
				quo_q <= den_q;
			end
			if (cmd.div_init) begin
				rem_q <= '0;
				bit_q <= '0;
			end
			if (cmd.div_step) begin
				rem_q <= ge ? trial_sub[BASE_WIDTH-1:0] : trial[BASE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
				bit_q <= bit_q + 1'b1;
			end
			if (cmd.accept) begin
				if (cmd.op_den) begin
					ed_q <= ed_q + 1'b1;
				end else begin
					en_q <= en_q + 1'b1;
				end
			end
		end
	end

	// Difference of the exponents, saturated to the result range.
	assign diff = $signed({{(DIFF_W - CNT_W){1'b0}}, en_q})
	            - $signed({{(DIFF_W - CNT_W){1'b0}}, ed_q});

	always_comb begin
		priority if (diff > DIFF_W'(VAL_MAX)) begin
			val_sat = VAL_W'(VAL_MAX);
		end else if (diff < DIFF_W'(VAL_MIN)) begin
			val_sat = VAL_W'(VAL_MIN);
		end else begin
			val_sat = diff[VAL_W-1:0];
		end
	end

	// Result registers; a small base forces the valuation to zero.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			base_error <= stat.base_small;
			valuation  <= stat.base_small ? '0 : val_sat;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

// File: rtl/core/p_adic_valuation_rational_top.sv
// Top level of the p-adic valuation block: joins controller and datapath.
// Depends on pav_pkg, pav_ctrl and pav_dp.
//
//  channel  handshake        payload
//  -------  ---------------  ---------------------------------------------
//  input    start, busy      prime_base, numerator_value, denominator_value
//  result   done (1 cycle)   valuation, base_error
//
// A transaction is taken when start is high and busy is low. Each trial division by the
// base is a check, one quotient bit per cycle and an evaluation. An operand with exponent
// e costs e + 1 divisions, a zero operand one check. The result strobe comes in the
// cycle busy falls. Reset clears only controller and strobe. The receiver cannot stall;
// a new transaction may start while done is high.
`default_nettype none

module p_adic_valuation_rational_top import pav_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [BASE_WIDTH-1:0]  prime_base,
	input  wire logic [VALUE_WIDTH-1:0] numerator_value,
	input  wire logic [VALUE_WIDTH-1:0] denominator_value,
	output logic                        done,
	output logic signed [VAL_W-1:0]     valuation,
	output logic                        base_error
);

	pav_cmd_t  cmd;
	pav_stat_t stat;

	pav_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	pav_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.prime_base        (prime_base),
		.numerator_value   (numerator_value),
		.denominator_value (denominator_value),
		.cmd               (cmd),
		.stat              (stat),
		.valuation         (valuation),
		.base_error        (base_error),
		.done              (done)
	);

endmodule

`default_nettype wire

// File: rtl/core/pav_checker.sv
// Port-level checks for the p-adic valuation block, bound to the top level.
// Depends on pav_pkg and p_adic_valuation_rational_top.
`default_nettype none

module pav_checker import pav_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   done,
	input wire logic signed [VAL_W-1:0] valuation,
	input wire logic                   base_error
);

	// An accepted transaction makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	// The result strobe comes exactly when busy drops.
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// The result strobe never comes twice in a row.
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A base error gives a zero valuation.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && base_error |-> valuation == '0)
		else $error("nonzero valuation with base error");

	// The valuation stays inside its saturation range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> valuation != VAL_W'(VAL_MIN - 1))
		else $error("valuation out of range");

endmodule

bind p_adic_valuation_rational_top pav_checker u_pav_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.valuation  (valuation),
	.base_error (base_error)
);

`default_nettype wire
